FILE: sv/ir_pd_pkg.sv
// Package for the pulse-distance IR decoder.
// Holds config/result types, register indexes and reset constants.
// No dependencies.
package ir_pd_pkg;

  localparam int unsigned CAP_W   = 16;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BITS    = 2'd3;

  // Reset values
  localparam logic [CAP_W-1:0] MIN_INTERVAL_RST  = 16'd500;
  localparam logic [CAP_W-1:0] MAX_INTERVAL_RST  = 16'd2500;
  localparam logic [CAP_W-1:0] ONE_THRESHOLD_RST = 16'd1500;
  localparam logic [CNT_W-1:0] FRAME_BITS_RST    = 6'd32;

  // Bit count saturates here
  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

  typedef struct packed {
    logic [CAP_W-1:0] min_interval;
    logic [CAP_W-1:0] max_interval;
    logic [CAP_W-1:0] one_threshold;
    logic [CNT_W-1:0] frame_bits;
  } cfg_t;

  typedef struct packed {
    logic              interval_ok;
    logic [CNT_W-1:0]  bit_count;
    logic              frame_done;
    logic [CODE_W-1:0] frame_code;
  } res_t;

endpackage

FILE: sv/ir_pd_if.sv
// Valid/ready channel interfaces for the IR decoder: capture beats in,
// decoded result beats out. Depends on ir_pd_pkg.
interface ir_pd_cap_if;
  import ir_pd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capture_value;

  modport source (output valid, output capture_value, input ready);
  modport sink   (input valid, input capture_value, output ready);
endinterface

interface ir_pd_res_if;
  import ir_pd_pkg::*;
  logic              valid;
  logic              ready;
  logic              interval_ok;
  logic [CNT_W-1:0]  bit_count;
  logic              frame_done;
  logic [CODE_W-1:0] frame_code;

  modport source (output valid, output interval_ok, output bit_count,
                  output frame_done, output frame_code, input ready);
  modport sink   (input valid, input interval_ok, input bit_count,
                  input frame_done, input frame_code, output ready);
endinterface

FILE: sv/ir_pulse_distance_decoder.sv
// Top level of the pulse-distance (NEC style) IR decoder.
// Depends on ir_pd_pkg, ir_pd_if, ir_pd_cfg and ir_pd_step.
//
// Usage:
//   cap_i  : valid/ready channel; each beat is a 16-bit down-counter value
//            captured at a falling edge of the IR line.
//   res_o  : valid/ready channel; one result beat per capture beat with
//            interval_ok, bit_count, frame_done and frame_code.
//   cfg_*  : write-only register port (min/max interval, one threshold,
//            frame bits), written while no beats are in flight.
// Path: a capture is held in the input register, then goes through one pass
//   of subtract/compare/shift into the result register.
// Throughput: one beat per cycle while res_o.ready is high. The input register
//   and the result register each hold a beat, so a new capture is taken while a
//   result waits; the only loop is the state update in the step logic.
// Reset: state (previous capture, shift bits, count, frame code) clears to
//   zero, registers take their defaults, both channels come up empty.
// Stall: when res_o.ready is low the result holds, the input register fills,
//   and cap_i.ready drops until the result beat is taken.
module ir_pulse_distance_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ir_pd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ir_pd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  ir_pd_cap_if.sink                         cap_i,
  ir_pd_res_if.source                       res_o
);
  import ir_pd_pkg::*;

  cfg_t             cfg;
  res_t             step_res;
  res_t             res_q;
  logic             out_vld_q;
  logic             in_vld_q;
  logic [CAP_W-1:0] cap_q;
  logic             advance;
  logic             in_take;

  ir_pd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // Handshake: move the input beat on when the result slot is free
  assign advance     = in_vld_q && (!out_vld_q || res_o.ready);
  assign cap_i.ready = !in_vld_q || advance;
  assign in_take     = cap_i.valid && cap_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (cap_i.ready) begin
      in_vld_q <= cap_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cap_q <= cap_i.capture_value;
    end
  end

  ir_pd_step u_step (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .fire_i          (advance),
    .capture_value_i (cap_q),
    .res_o           (step_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || res_o.ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.interval_ok = res_q.interval_ok;
  assign res_o.bit_count   = res_q.bit_count;
  assign res_o.frame_done  = res_q.frame_done;
  assign res_o.frame_code  = res_q.frame_code;

endmodule

FILE: sv/ir_pd_cfg.sv
// Configuration register file for the IR decoder.
// Depends on ir_pd_pkg.
module ir_pd_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 we_i,
  input  logic [ir_pd_pkg::CFG_IDX_W-1:0]      idx_i,
  input  logic [ir_pd_pkg::CFG_DATA_W-1:0]     data_i,
  output ir_pd_pkg::cfg_t                      cfg_o
);
  import ir_pd_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_MIN_INTERVAL:  cfg_d.min_interval  = data_i;
        CFG_MAX_INTERVAL:  cfg_d.max_interval  = data_i;
        CFG_ONE_THRESHOLD: cfg_d.one_threshold = data_i;
        CFG_FRAME_BITS:    cfg_d.frame_bits    = data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_interval  <= MIN_INTERVAL_RST;
      cfg_q.max_interval  <= MAX_INTERVAL_RST;
      cfg_q.one_threshold <= ONE_THRESHOLD_RST;
      cfg_q.frame_bits    <= FRAME_BITS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/ir_pd_step.sv
// Decode step: interval subtract, range check, bit shift, frame count.
// Holds the decoder state. Depends on ir_pd_pkg.
module ir_pd_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ir_pd_pkg::cfg_t               cfg_i,
  input  logic                          fire_i,
  input  logic [ir_pd_pkg::CAP_W-1:0]   capture_value_i,
  output ir_pd_pkg::res_t               res_o
);
  import ir_pd_pkg::*;

  logic [CAP_W-1:0]  prev_q;
  // the whole shift register reaches the output as the frame code
  logic [CODE_W-1:0] shift_q, shift_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CODE_W-1:0] code_q, code_d;

  logic [CAP_W-1:0]  interval;
  logic              ok;
  logic              done;

  // Interval between edges; timer counts down so prev minus current
  assign interval = prev_q - capture_value_i;
  assign ok = (interval >= cfg_i.min_interval) && (interval <= cfg_i.max_interval);

  always_comb begin
    shift_d = shift_q;
    count_d = count_q;
    code_d  = code_q;
    done    = 1'b0;
    if (!ok) begin
      count_d = '0;
    end else begin
      shift_d = {shift_q[CODE_W-2:0], interval > cfg_i.one_threshold};
      if (count_q != COUNT_MAX) begin
        count_d = count_q + 1'b1;
        if (count_d == cfg_i.frame_bits) begin
          done   = 1'b1;
          code_d = shift_d;
        end
      end
    end
  end

  // State update, once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      shift_q <= '0;
      count_q <= '0;
      code_q  <= '0;
    end else if (fire_i) begin
      prev_q  <= capture_value_i;
      shift_q <= shift_d;
      count_q <= count_d;
      code_q  <= code_d;
    end
  end

  assign res_o.interval_ok = ok;
  assign res_o.bit_count   = count_d;
  assign res_o.frame_done  = done;
  assign res_o.frame_code  = code_d;

endmodule

FILE: sv/ir_pd_chk.sv
// Port-level checker for the IR decoder, bound to the top level.
// Depends on ir_pd_pkg and ir_pulse_distance_decoder.
module ir_pd_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic                          interval_ok_i,
  input logic [ir_pd_pkg::CNT_W-1:0]   bit_count_i,
  input logic                          frame_done_i,
  input logic [ir_pd_pkg::CODE_W-1:0]  frame_code_i
);
  import ir_pd_pkg::*;

  // A frame only completes on an accepted bit
  a_done_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && frame_done_i |-> interval_ok_i)
    else $error("frame_done on a rejected interval");

  // A rejected interval clears the count
  a_reject_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !interval_ok_i |-> bit_count_i == '0)
    else $error("count not cleared on reject");

  // An accepted interval leaves a nonzero count
  a_ok_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && interval_ok_i |-> bit_count_i != '0)
    else $error("count zero after accepted bit");

  // Stalled result beat holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(frame_code_i)
      && $stable(bit_count_i) && $stable(frame_done_i) && $stable(interval_ok_i))
    else $error("result changed while stalled");

endmodule

bind ir_pulse_distance_decoder ir_pd_chk u_ir_pd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .interval_ok_i (res_o.interval_ok),
  .bit_count_i   (res_o.bit_count),
  .frame_done_i  (res_o.frame_done),
  .frame_code_i  (res_o.frame_code)
);
